// File: rtl/sfbp_pkg.sv
// sfbp_pkg: shared types, constants and lookup tables for the sensor frame bit packer
// no dependencies
`default_nettype none

package sfbp_pkg;

  localparam int FRAME_BYTES_DEF = 12;
  localparam int BYTE_POS_W      = 4;
  localparam int SLOT_W          = 5;
  localparam int SENSOR_W        = 4;
  localparam int READING_W       = 16;
  localparam int HDR_W           = 8;

  localparam logic [SLOT_W-1:0]  SLOT_COUNT = 5'd24;
  localparam logic [HDR_W-1:0]   HDR_FIRST  = 8'h01;
  localparam logic [HDR_W-1:0]   HDR_BASE   = 8'h0f;
  localparam logic [HDR_W-1:0]   HDR_NONE   = 8'h00;

  typedef struct packed {
    logic [SLOT_W-1:0]    slot_number;
    logic [SENSOR_W-1:0]  sensor_index;
    logic [READING_W-1:0] reading;
    logic                 frame_start;
    logic                 frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]            frame_byte;
    logic [BYTE_POS_W-1:0] byte_position;
    logic                  last_byte;
  } out_item_t;

  typedef enum logic [1:0] {
    W_SKIP = 2'd0,
    W_8    = 2'd1,
    W_12   = 2'd2
  } width_t;

  // fifo status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [HDR_W-1:0] header_code(input logic [SLOT_W-1:0] slot);
    logic [HDR_W-1:0] code;
    if (slot >= SLOT_COUNT) begin
      code = HDR_NONE;
    end else if (slot == '0) begin
      code = HDR_FIRST;
    end else begin
      code = HDR_BASE + {{(HDR_W-SLOT_W){1'b0}}, slot};
    end
    return code;
  endfunction

  // schedule rom: width of a sensor in a slot
  function automatic width_t sched_width(input logic [SLOT_W-1:0]   slot,
                                         input logic [SENSOR_W-1:0] sensor);
    width_t w;
    logic   hit;
    hit = 1'b0;
    w   = W_SKIP;
    case (sensor)
      4'd0, 4'd1, 4'd8: hit = 1'b1;
      4'd2:  hit = 1'b1;
      4'd3:  hit = ~slot[0];
      4'd4:  hit = slot[0];
      4'd5:  hit = ~slot[1];
      4'd6:  hit = slot[1];
      4'd7:  hit = (slot < 5'd12);
      4'd9:  hit = (slot >= 5'd12) && (slot < 5'd16);
      4'd10: hit = (slot < 5'd4) || (slot >= 5'd12);
      4'd11: hit = (slot >= 5'd4) && (slot < 5'd9);
      4'd12: hit = (slot >= 5'd9) && (slot < 5'd12);
      4'd13: hit = (slot >= 5'd16) && (slot < 5'd20);
      4'd14: hit = (slot >= 5'd20);
      default: hit = 1'b0;
    endcase
    if (slot >= SLOT_COUNT) begin
      hit = 1'b0;
    end
    if (hit) begin
      if ((sensor == 4'd2) || (sensor == 4'd3) || (sensor == 4'd4)) begin
        w = W_8;
      end else begin
        w = W_12;
      end
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sfbp_front.sv
// sfbp_front: accepts readings, looks up header and width, packs the frame store
// depends on sfbp_pkg
`default_nettype none

module sfbp_front #(
  parameter int FRAME_BYTES = sfbp_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire sfbp_pkg::in_item_t     in_data,
  input  wire sfbp_pkg::fifo_stat_t   fifo_stat,
  output logic                        push,
  output logic [FRAME_BYTES*8-1:0]    push_frame
);
  import sfbp_pkg::*;

  localparam int STORE_W = FRAME_BYTES * 8;

  logic [STORE_W-1:0] store_r, store_nxt;
  logic [STORE_W-1:0] base;
  logic               accept;
  width_t             w;

  assign in_ready = ~fifo_stat.full;
  assign accept   = in_valid & in_ready;
  assign w        = sched_width(in_data.slot_number, in_data.sensor_index);

  always_comb begin
    // start clears the store down to the header before the reading is shifted in
    base = in_data.frame_start
         ? {{(STORE_W-HDR_W){1'b0}}, header_code(in_data.slot_number)}
         : store_r;
    case (w)
      W_8:     store_nxt = {base[STORE_W-9:0], in_data.reading[7:0]};
      W_12:    store_nxt = {base[STORE_W-13:0], in_data.reading[11:0]};
      W_SKIP:  store_nxt = base;
      default: store_nxt = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
    end else if (accept) begin
      store_r <= store_nxt;
    end
  end

  assign push       = accept & in_data.frame_end;
  assign push_frame = store_nxt;

endmodule

`default_nettype wire

// File: rtl/sfbp_frame_fifo.sv
// sfbp_frame_fifo: two-entry queue of finished frames between front and back
// depends on sfbp_pkg
`default_nettype none

module sfbp_frame_fifo #(
  parameter int FRAME_BYTES = sfbp_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire logic [FRAME_BYTES*8-1:0] push_frame,
  input  wire logic                   pop,
  output logic [FRAME_BYTES*8-1:0]    head_frame,
  output sfbp_pkg::fifo_stat_t        stat
);
  import sfbp_pkg::*;

  localparam int STORE_W = FRAME_BYTES * 8;

  logic [STORE_W-1:0] entry_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         count_r, count_nxt;

  assign head_frame = entry_r[rd_ptr_r];
  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_frame;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sfbp_back.sv
// sfbp_back: serializes queued frames into bytes, most significant first
// depends on sfbp_pkg
`default_nettype none

module sfbp_back #(
  parameter int FRAME_BYTES = sfbp_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire sfbp_pkg::fifo_stat_t     fifo_stat,
  input  wire logic [FRAME_BYTES*8-1:0] head_frame,
  output logic                          pop,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output sfbp_pkg::out_item_t           out_data
);
  import sfbp_pkg::*;

  localparam int STORE_W = FRAME_BYTES * 8;
  localparam int CNT_W   = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_BYTES - 1);

  logic [STORE_W-1:0] shift_r;
  logic [CNT_W-1:0]   pos_r;
  logic               busy_r;
  logic               out_valid_r;
  out_item_t          out_data_r;
  logic               slot_free, emit, emit_last;

  assign slot_free = ~out_valid_r | out_ready;
  assign emit      = busy_r & slot_free;
  assign emit_last = emit & (pos_r == LAST_POS);
  // load the next frame when idle or once the current one has handed over its last byte
  assign pop       = ~fifo_stat.empty & (~busy_r | emit_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
        pos_r  <= '0;
      end else if (emit_last) begin
        busy_r <= 1'b0;
      end else if (emit) begin
        pos_r <= pos_r + CNT_W'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shift_r <= head_frame;
    end else if (emit) begin
      shift_r <= {shift_r[STORE_W-9:0], 8'h00};
    end
    if (emit) begin
      out_data_r.frame_byte    <= shift_r[STORE_W-1 -: 8];
      out_data_r.byte_position <= BYTE_POS_W'(pos_r);
      out_data_r.last_byte     <= (pos_r == LAST_POS);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/sensor_frame_bit_packer.sv
// sensor_frame_bit_packer: top level, packs sensor readings into a telemetry frame
// depends on sfbp_pkg, sfbp_front, sfbp_frame_fifo, sfbp_back
//
//   channel  | ports                           | payload
//   ---------+---------------------------------+-----------------------------------
//   input    | in_valid, in_ready, in_data     | slot, sensor, reading, start, end
//   result   | out_valid, out_ready, out_data  | frame byte, byte position, last
//
// one reading is taken every cycle while in_ready is high; packing into the frame
// store is a single shift by 0, 8 or 12 bits plus the header on a start request
// an end request copies the packed frame into a two-entry frame queue; the back end
// drains it one byte per cycle while out_ready is high, FRAME_BYTES bytes a frame
// in_ready drops only while both queue entries are waiting to be serialized
// rst_n is synchronous, active low; it clears the frame store and empties the queue
`default_nettype none

module sensor_frame_bit_packer #(
  parameter int FRAME_BYTES = sfbp_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sfbp_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sfbp_pkg::out_item_t       out_data
);
  import sfbp_pkg::*;

  localparam int STORE_W = FRAME_BYTES * 8;

  // front to queue
  logic               push;
  logic [STORE_W-1:0] push_frame;
  // queue to back
  logic               pop;
  logic [STORE_W-1:0] head_frame;
  fifo_stat_t         fifo_stat;

  // front: classify the request and update the frame store
  sfbp_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .fifo_stat  (fifo_stat),
    .push       (push),
    .push_frame (push_frame)
  );

  // finished frames wait here so the front keeps packing during the byte run
  sfbp_frame_fifo #(.FRAME_BYTES(FRAME_BYTES)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head_frame (head_frame),
    .stat       (fifo_stat)
  );

  // back: byte serializer with registered output
  sfbp_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_stat  (fifo_stat),
    .head_frame (head_frame),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
